@@ src/arc_pr_pkg.sv @@
// shared types and constants of the adaptive replacement cache directory
package arc_pr_pkg;

  // default sizing
  localparam int CAPACITY_MAX_DEF = 32;
  localparam int PAGE_BITS_DEF    = 32;

  // capacity register
  localparam int                 CFG_W     = 6;
  localparam logic [CFG_W-1:0]   CAP_RESET = 6'd32;

  // list codes held in the directory
  typedef enum logic [1:0] {
    L_T1 = 2'd0,
    L_T2 = 2'd1,
    L_B1 = 2'd2,
    L_B2 = 2'd3
  } list_t;

  // what a search sweep looks for
  typedef enum logic [1:0] {
    F_TAG  = 2'd0,
    F_LRU  = 2'd1,
    F_FREE = 2'd2
  } find_t;

endpackage

@@ src/arc_pr_ram.sv @@
// generic simple dual port ram with registered read
module arc_pr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/arc_page_replacement.sv @@
// adaptive replacement cache directory, top level
//
// Each request on the slave stream is one page access; one result per access
// comes out on the master stream (hit, evicted_valid, evicted_page). The
// directory of 2*CAPACITY_MAX entries lives in two registered-read
// memories (tags, and list/rank per entry) with valid bits in flip-flops, so
// no clearing pass is needed after reset or a capacity write. Each lookup,
// search and update of an access is a full sweep of the directory memory,
// DEPTH = 2*CAPACITY_MAX entries. A resident hit takes a lookup and a move
// sweep; a ghost hit takes up to four sweeps plus a bit-serial divide; a
// miss takes up to seven sweeps. A finished access holds while the previous
// result still waits on the master side. A new request is taken while the
// previous result still waits on the master side. Writing capacity clears
// the directory and the target; write it only while idle.
module arc_page_replacement #(
  parameter int CAPACITY_MAX = arc_pr_pkg::CAPACITY_MAX_DEF,
  parameter int PAGE_BITS    = arc_pr_pkg::PAGE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // slave stream, tdata: page
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [((PAGE_BITS+7)/8)*8-1:0]      s_tdata,
  // master stream, tdata: hit, evicted_valid, evicted_page
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [((PAGE_BITS+2+7)/8)*8-1:0]    m_tdata,
  // capacity register
  input  logic                                cfg_we,
  input  logic [arc_pr_pkg::CFG_W-1:0]        cfg_wdata
);

  localparam int DEPTH  = 2 * CAPACITY_MAX;
  localparam int AW     = $clog2(DEPTH);
  localparam int RANK_W = AW;
  localparam int SZ_W   = $clog2(DEPTH + 1);
  localparam int CNT_W  = $clog2(SZ_W + 1);
  localparam int MW     = 2 + RANK_W;
  localparam int OUT_W  = ((PAGE_BITS + 2 + 7) / 8) * 8;

  typedef enum logic [4:0] {
    IDLE, LOOKUP, CLASSIFY, DIV, PUPD, DROP_F, DROP_M, REPL_S, REPL_F,
    REPL_M, T1EV_F, T1EV_M, MOVE_S, MOVE_M, FREE_S, FREE_F, HOLD
  } state_t;

  state_t state, state_next;
  logic   done_st;

  // configuration and adaptive state
  logic [arc_pr_pkg::CFG_W-1:0] capacity;
  logic [SZ_W-1:0]              c_eff;
  logic [SZ_W-1:0]              tp;
  logic [SZ_W-1:0]              sizes [4];
  logic [DEPTH-1:0]             valid;

  // current request
  logic [PAGE_BITS-1:0] page_r;
  logic                 hit_r, evv_r, ghost;
  logic [PAGE_BITS-1:0] evp_r;

  // output register
  logic                 out_hit, out_evv;
  logic [PAGE_BITS-1:0] out_evp;

  // sweep engine
  logic                  sw_run, sw_find, sw_done, p_valid;
  logic [AW-1:0]         sw_cnt, p_addr;
  arc_pr_pkg::find_t     f_mode;
  arc_pr_pkg::list_t     f_list;
  logic                  match;

  // search results
  logic                  f_found;
  logic [AW-1:0]         f_idx;
  arc_pr_pkg::list_t     f_lst;
  logic [RANK_W-1:0]     f_rank;
  logic [PAGE_BITS-1:0]  f_tag;

  // entry that hit in the directory
  logic [AW-1:0]         hi_idx;
  arc_pr_pkg::list_t     hi_list;
  logic [RANK_W-1:0]     hi_rank;
  logic                  hi_found;

  // update sweep parameters
  logic [AW-1:0]         m_j;
  arc_pr_pkg::list_t     m_ol, m_nl;
  logic [RANK_W-1:0]     m_orank;
  logic                  m_unlink, m_kill;

  // divider
  logic [SZ_W:0]         dv_rem, rem_sh;
  logic [SZ_W-1:0]       dv_q, dv_den, dv_d;
  logic [CNT_W-1:0]      dv_cnt;
  logic [SZ_W:0]         p_sum;

  // launch controls
  logic                  fgo, mgo, set_hit, set_ev, div_go, p_go, tag_we;
  arc_pr_pkg::find_t     fmode;
  arc_pr_pkg::list_t     flist, mol, mnl, repl_from;
  logic [AW-1:0]         mj;
  logic [RANK_W-1:0]     morank;
  logic                  munl, mkill;

  // memory ports
  logic [PAGE_BITS-1:0]  tag_rd;
  logic [MW-1:0]         meta_rd, meta_wd;
  arc_pr_pkg::list_t     rd_list, wr_list;
  logic [RANK_W-1:0]     rd_rank, wr_rank;
  logic                  meta_we;

  logic [SZ_W:0]         l1;
  logic [SZ_W+1:0]       total;
  logic                  rdec, rinc, hdec, hinc;

  arc_pr_ram #(.WIDTH(PAGE_BITS), .DEPTH(DEPTH)) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (f_idx),
    .wdata (page_r),
    .raddr (sw_cnt),
    .rdata (tag_rd)
  );

  arc_pr_ram #(.WIDTH(MW), .DEPTH(DEPTH)) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (p_addr),
    .wdata (meta_wd),
    .raddr (sw_cnt),
    .rdata (meta_rd)
  );

  assign rd_list  = arc_pr_pkg::list_t'(meta_rd[MW-1:RANK_W]);
  assign rd_rank  = meta_rd[RANK_W-1:0];
  assign meta_we  = p_valid && !sw_find;
  assign meta_wd  = {wr_list, wr_rank};
  assign s_tready = (state == IDLE);
  assign m_tdata  = OUT_W'({out_evp, out_evv, out_hit});

  // effective capacity
  always_comb begin
    if (capacity == '0) begin
      c_eff = SZ_W'(1);
    end else if (int'(capacity) > CAPACITY_MAX) begin
      c_eff = SZ_W'(CAPACITY_MAX);
    end else begin
      c_eff = SZ_W'(capacity);
    end
  end

  // list totals for the miss path
  assign l1    = {1'b0, sizes[arc_pr_pkg::L_T1]} + {1'b0, sizes[arc_pr_pkg::L_B1]};
  assign total = {1'b0, l1} + {2'b0, sizes[arc_pr_pkg::L_T2]}
               + {2'b0, sizes[arc_pr_pkg::L_B2]};

  // replace picks the t1 lru when t1 is nonempty and over target, or at target on a b2 ghost hit
  always_comb begin
    if (sizes[arc_pr_pkg::L_T1] != '0 &&
        (sizes[arc_pr_pkg::L_T1] > tp ||
         (ghost && hi_list == arc_pr_pkg::L_B2 && sizes[arc_pr_pkg::L_T1] == tp))) begin
      repl_from = arc_pr_pkg::L_T1;
    end else begin
      repl_from = arc_pr_pkg::L_T2;
    end
  end

  // search match on the entry read back this cycle
  always_comb begin
    unique case (f_mode)
      arc_pr_pkg::F_TAG:  match = valid[p_addr] && tag_rd == page_r;
      arc_pr_pkg::F_LRU:  match = valid[p_addr] && rd_list == f_list &&
                                  sizes[f_list] != '0 &&
                                  SZ_W'(rd_rank) == sizes[f_list] - SZ_W'(1);
      arc_pr_pkg::F_FREE: match = !valid[p_addr];
      default:            match = 1'b0;
    endcase
  end

  // rank update of the entry read back this cycle
  always_comb begin
    rdec    = m_unlink && rd_list == m_ol && rd_rank > m_orank;
    rinc    = !m_kill && rd_list == m_nl;
    wr_list = rd_list;
    wr_rank = rd_rank;
    if (p_addr == m_j) begin
      wr_list = m_nl;
      wr_rank = '0;
    end else if (valid[p_addr]) begin
      wr_rank = rd_rank - RANK_W'(rdec) + RANK_W'(rinc);
    end
  end

  // rank of the hit entry follows other updates
  assign hdec = munl && hi_list == mol && hi_rank > morank;
  assign hinc = !mkill && hi_list == mnl;

  // divider step and target update values
  assign rem_sh = {dv_rem[SZ_W-1:0], dv_q[SZ_W-1]};
  assign dv_d   = (dv_den == '0 || dv_q == '0) ? SZ_W'(1) : dv_q;
  assign p_sum  = {1'b0, tp} + {1'b0, dv_d};

  // sequencer
  always_comb begin
    state_next = state;
    fgo = 1'b0;  fmode = arc_pr_pkg::F_TAG;  flist = arc_pr_pkg::L_T1;
    mgo = 1'b0;  mj = f_idx;  mol = f_lst;  morank = f_rank;
    mnl = arc_pr_pkg::L_T2;  munl = 1'b1;  mkill = 1'b0;
    set_hit = 1'b0;  set_ev = 1'b0;  div_go = 1'b0;  p_go = 1'b0;  tag_we = 1'b0;
    done_st = 1'b0;
    unique case (state)
      IDLE: begin
        if (s_tvalid) begin
          fgo = 1'b1;  fmode = arc_pr_pkg::F_TAG;
          state_next = LOOKUP;
        end
      end
      LOOKUP: begin
        if (sw_done) state_next = CLASSIFY;
      end
      CLASSIFY: begin
        if (hi_found && (hi_list == arc_pr_pkg::L_T1 || hi_list == arc_pr_pkg::L_T2)) begin
          set_hit = 1'b1;
          state_next = MOVE_S;
        end else if (hi_found) begin
          div_go = 1'b1;
          state_next = DIV;
        end else if (l1 >= {1'b0, c_eff}) begin
          fgo = 1'b1;  fmode = arc_pr_pkg::F_LRU;
          if (sizes[arc_pr_pkg::L_T1] < c_eff) begin
            flist = arc_pr_pkg::L_B1;
            state_next = DROP_F;
          end else begin
            flist = arc_pr_pkg::L_T1;
            state_next = T1EV_F;
          end
        end else if (total >= {2'b0, c_eff}) begin
          if (total >= {1'b0, c_eff, 1'b0}) begin
            fgo = 1'b1;  fmode = arc_pr_pkg::F_LRU;  flist = arc_pr_pkg::L_B2;
            state_next = DROP_F;
          end else begin
            state_next = REPL_S;
          end
        end else begin
          state_next = FREE_S;
        end
      end
      DIV: begin
        if (dv_cnt == '0) state_next = PUPD;
      end
      PUPD: begin
        p_go = 1'b1;
        state_next = REPL_S;
      end
      DROP_F: begin
        if (sw_done) begin
          if (f_found) begin
            mgo = 1'b1;  mkill = 1'b1;
            state_next = DROP_M;
          end else begin
            state_next = REPL_S;
          end
        end
      end
      DROP_M: begin
        if (sw_done) state_next = REPL_S;
      end
      REPL_S: begin
        fgo = 1'b1;  fmode = arc_pr_pkg::F_LRU;  flist = repl_from;
        state_next = REPL_F;
      end
      REPL_F: begin
        if (sw_done) begin
          if (f_found) begin
            mgo = 1'b1;  set_ev = 1'b1;
            mnl = (f_lst == arc_pr_pkg::L_T1) ? arc_pr_pkg::L_B1 : arc_pr_pkg::L_B2;
            state_next = REPL_M;
          end else begin
            state_next = ghost ? MOVE_S : FREE_S;
          end
        end
      end
      REPL_M: begin
        if (sw_done) state_next = ghost ? MOVE_S : FREE_S;
      end
      T1EV_F: begin
        if (sw_done) begin
          if (f_found) begin
            mgo = 1'b1;  mkill = 1'b1;  set_ev = 1'b1;
            state_next = T1EV_M;
          end else begin
            state_next = FREE_S;
          end
        end
      end
      T1EV_M: begin
        if (sw_done) state_next = FREE_S;
      end
      MOVE_S: begin
        mgo = 1'b1;  mj = hi_idx;  mol = hi_list;  morank = hi_rank;
        mnl = arc_pr_pkg::L_T2;
        state_next = MOVE_M;
      end
      MOVE_M: begin
        if (sw_done) done_st = 1'b1;
      end
      FREE_S: begin
        fgo = 1'b1;  fmode = arc_pr_pkg::F_FREE;
        state_next = FREE_F;
      end
      FREE_F: begin
        if (sw_done) begin
          if (f_found) begin
            mgo = 1'b1;  munl = 1'b0;  mol = arc_pr_pkg::L_T1;
            mnl = arc_pr_pkg::L_T1;  tag_we = 1'b1;
            state_next = MOVE_M;
          end else begin
            done_st = 1'b1;
          end
        end
      end
      HOLD: begin
        done_st = 1'b1;
      end
      default: state_next = IDLE;
    endcase
    // finished access waits for the output register
    if (done_st) begin
      state_next = (!m_tvalid || m_tready) ? IDLE : HOLD;
    end
  end

  // state, sweep engine and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      capacity <= arc_pr_pkg::CAP_RESET;
      tp       <= '0;
      valid    <= '0;
      for (int l = 0; l < 4; l++) sizes[l] <= '0;
      sw_run   <= 1'b0;
      p_valid  <= 1'b0;
      sw_done  <= 1'b0;
      m_tvalid <= 1'b0;
      dv_cnt   <= '0;
    end else begin
      state <= state_next;

      // sweep address and read pipeline
      if (sw_run) begin
        sw_cnt <= sw_cnt + AW'(1);
        if (sw_cnt == AW'(DEPTH - 1)) sw_run <= 1'b0;
      end
      p_valid <= sw_run;
      p_addr  <= sw_cnt;
      sw_done <= p_valid && p_addr == AW'(DEPTH - 1);

      // first match of a search
      if (p_valid && sw_find && match && !f_found) begin
        f_found <= 1'b1;
        f_idx   <= p_addr;
        f_lst   <= rd_list;
        f_rank  <= rd_rank;
        f_tag   <= tag_rd;
      end

      // accept a request
      if (state == IDLE && s_tvalid) begin
        page_r <= s_tdata[PAGE_BITS-1:0];
        hit_r  <= 1'b0;
        evv_r  <= 1'b0;
        evp_r  <= '0;
        ghost  <= 1'b0;
      end

      // start a search sweep
      if (fgo) begin
        sw_run  <= 1'b1;
        sw_cnt  <= '0;
        sw_find <= 1'b1;
        f_mode  <= fmode;
        f_list  <= flist;
        f_found <= 1'b0;
      end

      // lookup result becomes the hit entry
      if (state == LOOKUP && sw_done) begin
        hi_found <= f_found;
        hi_idx   <= f_idx;
        hi_list  <= f_lst;
        hi_rank  <= f_rank;
      end
      if (state == CLASSIFY && hi_found &&
          (hi_list == arc_pr_pkg::L_B1 || hi_list == arc_pr_pkg::L_B2)) begin
        ghost <= 1'b1;
      end

      // start an update sweep
      if (mgo) begin
        sw_run   <= 1'b1;
        sw_cnt   <= '0;
        sw_find  <= 1'b0;
        m_j      <= mj;
        m_ol     <= mol;
        m_orank  <= morank;
        m_nl     <= mnl;
        m_unlink <= munl;
        m_kill   <= mkill;
        valid[mj] <= !mkill;
        for (int l = 0; l < 4; l++) begin
          sizes[l] <= sizes[l]
                    - SZ_W'(munl && arc_pr_pkg::list_t'(l) == mol && sizes[l] != '0)
                    + SZ_W'(!mkill && arc_pr_pkg::list_t'(l) == mnl);
        end
        if (mj != hi_idx) begin
          hi_rank <= hi_rank - RANK_W'(hdec) + RANK_W'(hinc);
        end
      end

      if (set_hit) hit_r <= 1'b1;
      if (set_ev) begin
        evv_r <= 1'b1;
        evp_r <= f_tag;
      end

      // ratio of ghost list sizes, one quotient bit a cycle
      if (div_go) begin
        dv_rem <= '0;
        dv_cnt <= CNT_W'(SZ_W);
        if (hi_list == arc_pr_pkg::L_B1) begin
          dv_q   <= sizes[arc_pr_pkg::L_B2];
          dv_den <= sizes[arc_pr_pkg::L_B1];
        end else begin
          dv_q   <= sizes[arc_pr_pkg::L_B1];
          dv_den <= sizes[arc_pr_pkg::L_B2];
        end
      end else if (state == DIV && dv_cnt != '0) begin
        dv_cnt <= dv_cnt - CNT_W'(1);
        if (rem_sh >= {1'b0, dv_den}) begin
          dv_rem <= rem_sh - {1'b0, dv_den};
          dv_q   <= {dv_q[SZ_W-2:0], 1'b1};
        end else begin
          dv_rem <= rem_sh;
          dv_q   <= {dv_q[SZ_W-2:0], 1'b0};
        end
      end

      // adapt the target
      if (p_go) begin
        if (hi_list == arc_pr_pkg::L_B1) begin
          tp <= (p_sum > {1'b0, c_eff}) ? c_eff : p_sum[SZ_W-1:0];
        end else begin
          tp <= (tp > dv_d) ? tp - dv_d : '0;
        end
      end

      // result register
      if (done_st && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
        out_hit  <= hit_r;
        out_evv  <= evv_r;
        out_evp  <= evp_r;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      // capacity write clears the directory
      if (cfg_we) begin
        capacity <= cfg_wdata;
        valid    <= '0;
        tp       <= '0;
        for (int l = 0; l < 4; l++) sizes[l] <= '0;
      end
    end
  end

`ifndef SYNTHESIS
  a_idle_no_sweep: assert property (@(posedge clk) disable iff (rst)
    (state == IDLE) |-> !sw_run)
    else $error("sweep running while idle");

  a_target_bound: assert property (@(posedge clk) disable iff (rst)
    (state == IDLE) |-> (tp <= c_eff))
    else $error("target above capacity");

  a_size_bound: assert property (@(posedge clk) disable iff (rst)
    (int'(sizes[0]) + int'(sizes[1]) + int'(sizes[2]) + int'(sizes[3]) <= DEPTH))
    else $error("list sizes exceed directory depth");

  a_evict_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[1]) |-> (m_tdata[PAGE_BITS+1:2] == '0))
    else $error("evicted page set without eviction");
`endif

endmodule
